>>> src/clcd_pkg.sv
// ============================================================================
// clcd_pkg: shared types and constants of the character-lcd sequencer
// mode codes, field widths, strobe timing and the power-up init table
// ============================================================================
package clcd_pkg;

  localparam int ModeW   = 3;
  localparam int ValueW  = 8;
  localparam int ColW    = 6;
  localparam int RowW    = 2;
  localparam int NibW    = 4;
  localparam int BeforeW = 16;
  localparam int AfterW  = 13;
  localparam int StepW   = 4;

  localparam int ROW_TWO_BASE_DEF = 64;

  typedef logic [ModeW-1:0]   mode_t;
  typedef logic [ValueW-1:0]  byte_t;
  typedef logic [ColW-1:0]    col_t;
  typedef logic [RowW-1:0]    row_t;
  typedef logic [NibW-1:0]    nib_t;
  typedef logic [BeforeW-1:0] before_t;
  typedef logic [AfterW-1:0]  after_t;
  typedef logic [StepW-1:0]   step_t;

  localparam mode_t MODE_INIT    = 3'd0;
  localparam mode_t MODE_CMD     = 3'd1;
  localparam mode_t MODE_DATA    = 3'd2;
  localparam mode_t MODE_GOTO    = 3'd3;
  localparam mode_t MODE_CLEAR   = 3'd4;
  localparam mode_t MODE_HOME    = 3'd5;
  localparam mode_t MODE_DISP_ON = 3'd6;
  localparam mode_t MODE_NONE    = 3'd7;

  localparam byte_t CMD_CLEAR   = 8'h01;
  localparam byte_t CMD_HOME    = 8'h02;
  localparam byte_t CMD_DISP_ON = 8'h0C;
  localparam byte_t CMD_DDRAM   = 8'h80;

  localparam before_t POWERUP_US     = 16'd50000;
  localparam after_t  WAKE_FIRST_US  = 13'd5000;
  localparam after_t  WAKE_US        = 13'd150;
  localparam after_t  POST_BYTE_US   = 13'd40;
  localparam after_t  CLEAR_EXTRA_US = 13'd2000;

  localparam step_t INIT_LAST_STEP = 4'd13;
  localparam step_t BYTE_LAST_STEP = 4'd1;

  // request fields as seen by the datapath
  typedef struct packed {
    mode_t mode;
    byte_t value;
    col_t  col;
    row_t  row;
    logic  cursor_show;
    logic  cursor_blink;
  } req_t;

  // one enable strobe without its last flag
  typedef struct packed {
    logic    rs;
    nib_t    nibble;
    before_t wait_before;
    after_t  wait_after;
  } strobe_t;

  // controller to datapath
  typedef struct packed {
    logic  capture;
    logic  load;
    step_t step;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic none;
    logic last;
  } dp_stat_t;

  // power-up init run: wake-up nibbles, then 0x28, 0x08, clear, 0x06, 0x0c
  function automatic strobe_t init_strobe(step_t step);
    strobe_t s;
    s.rs          = 1'b0;
    s.wait_before = '0;
    s.wait_after  = '0;
    s.nibble      = '0;
    unique case (step)
      4'd0: begin
        s.nibble      = 4'h3;
        s.wait_before = POWERUP_US;
        s.wait_after  = WAKE_FIRST_US;
      end
      4'd1: begin
        s.nibble     = 4'h3;
        s.wait_after = WAKE_US;
      end
      4'd2: begin
        s.nibble     = 4'h3;
        s.wait_after = WAKE_US;
      end
      4'd3: begin
        s.nibble     = 4'h2;
        s.wait_after = WAKE_US;
      end
      4'd4:  s.nibble = 4'h2;
      4'd5: begin
        s.nibble     = 4'h8;
        s.wait_after = POST_BYTE_US;
      end
      4'd6:  s.nibble = 4'h0;
      4'd7: begin
        s.nibble     = 4'h8;
        s.wait_after = POST_BYTE_US;
      end
      4'd8:  s.nibble = 4'h0;
      4'd9: begin
        s.nibble     = 4'h1;
        s.wait_after = POST_BYTE_US + CLEAR_EXTRA_US;
      end
      4'd10: s.nibble = 4'h0;
      4'd11: begin
        s.nibble     = 4'h6;
        s.wait_after = POST_BYTE_US;
      end
      4'd12: s.nibble = 4'h0;
      4'd13: begin
        s.nibble     = 4'hC;
        s.wait_after = POST_BYTE_US;
      end
      default: s.nibble = '0;
    endcase
    return s;
  endfunction

endpackage

>>> src/clcd_req_if.sv
// ============================================================================
// clcd_req_if: request channel of the character-lcd sequencer
// valid/ready channel carrying one write request
// ============================================================================
interface clcd_req_if;
  logic               valid;
  logic               ready;
  clcd_pkg::mode_t    mode;
  clcd_pkg::byte_t    value;
  clcd_pkg::col_t     col;
  clcd_pkg::row_t     row;
  logic               cursor_show;
  logic               cursor_blink;

  modport source (output valid, mode, value, col, row, cursor_show, cursor_blink,
                  input ready);
  modport sink   (input valid, mode, value, col, row, cursor_show, cursor_blink,
                  output ready);
endinterface

>>> src/clcd_strobe_if.sv
// ============================================================================
// clcd_strobe_if: strobe channel of the character-lcd sequencer
// valid/ready channel carrying one enable strobe with its waits
// ============================================================================
interface clcd_strobe_if;
  logic                valid;
  logic                ready;
  logic                reg_select;
  clcd_pkg::nib_t      nibble;
  clcd_pkg::before_t   wait_before_us;
  clcd_pkg::after_t    wait_after_us;
  logic                last;

  modport source (output valid, reg_select, nibble, wait_before_us, wait_after_us, last,
                  input ready);
  modport sink   (input valid, reg_select, nibble, wait_before_us, wait_after_us, last,
                  output ready);
endinterface

>>> src/clcd_datapath.sv
// ============================================================================
// clcd_datapath: request latch, strobe generation and output register
// turns the latched request and the step index into one strobe
// ============================================================================
module clcd_datapath #(
  parameter int ROW_TWO_BASE = clcd_pkg::ROW_TWO_BASE_DEF
) (
  input  logic                clk,
  input  clcd_pkg::req_t      req,
  input  clcd_pkg::ctrl_cmd_t cmd,
  output clcd_pkg::dp_stat_t  stat,
  output clcd_pkg::strobe_t   strb,
  output logic                strb_last
);
  import clcd_pkg::*;

  mode_t   mode_r;
  byte_t   byte_r;
  logic    rs_r;
  logic    long_r;
  strobe_t strb_r;
  logic    last_r;

  byte_t   byte_nxt;
  logic    rs_nxt;
  logic    long_nxt;
  byte_t   goto_addr;
  strobe_t cur;
  logic    cur_last;

  assign goto_addr = {2'b00, req.col} + ((req.row != '0) ? ValueW'(ROW_TWO_BASE) : '0);

  // byte to send for the single-byte modes
  always_comb begin
    byte_nxt = '0;
    rs_nxt   = 1'b0;
    long_nxt = 1'b0;
    unique case (req.mode)
      MODE_CMD:     byte_nxt = req.value;
      MODE_DATA: begin
        byte_nxt = req.value;
        rs_nxt   = 1'b1;
      end
      MODE_GOTO:    byte_nxt = CMD_DDRAM | goto_addr;
      MODE_CLEAR: begin
        byte_nxt = CMD_CLEAR;
        long_nxt = 1'b1;
      end
      MODE_HOME: begin
        byte_nxt = CMD_HOME;
        long_nxt = 1'b1;
      end
      MODE_DISP_ON: byte_nxt = CMD_DISP_ON | {6'b0, req.cursor_show, req.cursor_blink};
      default:      byte_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= req.mode;
      byte_r <= byte_nxt;
      rs_r   <= rs_nxt;
      long_r <= long_nxt;
    end
  end

  // strobe for the current step
  always_comb begin
    if (mode_r == MODE_INIT) begin
      cur      = init_strobe(cmd.step);
      cur_last = (cmd.step == INIT_LAST_STEP);
    end else begin
      cur.rs          = rs_r;
      cur.wait_before = '0;
      if (!cmd.step[0]) begin
        cur.nibble     = byte_r[7:4];
        cur.wait_after = '0;
      end else begin
        cur.nibble     = byte_r[3:0];
        cur.wait_after = POST_BYTE_US + (long_r ? CLEAR_EXTRA_US : '0);
      end
      cur_last = (cmd.step == BYTE_LAST_STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      strb_r <= cur;
      last_r <= cur_last;
    end
  end

  assign stat.none = (req.mode == MODE_NONE);
  assign stat.last = cur_last;
  assign strb      = strb_r;
  assign strb_last = last_r;

endmodule

>>> src/clcd_ctrl.sv
// ============================================================================
// clcd_ctrl: sequencing state machine of the character-lcd sequencer
// accepts requests, steps through strobes and owns the output valid
// ============================================================================
module clcd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  clcd_pkg::dp_stat_t  stat,
  output clcd_pkg::ctrl_cmd_t cmd
);
  import clcd_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic  state_r, state_nxt;
  step_t step_r, step_nxt;
  logic  valid_r, valid_nxt;
  logic  accept;
  logic  slot_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !valid_r || out_ready;

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    cmd.capture = accept;
    cmd.load    = 1'b0;
    cmd.step    = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && !stat.none) begin
          state_nxt = ST_EMIT;
          step_nxt  = '0;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd.load = 1'b1;
          if (stat.last) begin
            state_nxt = ST_IDLE;
          end else begin
            step_nxt = step_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_valid = valid_r;

endmodule

>>> src/char_lcd_4bit_sequencer.sv
// ============================================================================
// char_lcd_4bit_sequencer: hd44780-style 4-bit write sequencer
// expands each request into the run of enable strobes for a character lcd
// ============================================================================
// usage
//   in_req is a valid/ready request channel: mode, value, col, row,
//   cursor_show and cursor_blink. out_strb is a valid/ready strobe channel:
//   one transfer per enable strobe with reg_select, nibble, wait_before_us,
//   wait_after_us and last, which marks the final strobe of a request.
//   a byte request gives two strobes, power-up init gives fourteen, and
//   mode 7 is taken and gives none.
// sequencing and throughput
//   after the request transfer the state machine enters its emit state
//   and loads the first strobe into the output register once that is free;
//   strobes then follow one per cycle while out_strb is ready. the state
//   machine's step counter walks them one per cycle while that holds, and
//   a new request is taken once the previous one's last strobe is registered.
// reset and stall
//   rst_n (synchronous, active low) clears the strobe valid and returns the
//   state machine to idle, ready for a request.
//   a stalled receiver holds the output register and the step counter;
//   nothing is lost or repeated.
// ============================================================================
module char_lcd_4bit_sequencer #(
  parameter int ROW_TWO_BASE = clcd_pkg::ROW_TWO_BASE_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  clcd_req_if.sink        in_req,
  clcd_strobe_if.source   out_strb
);
  import clcd_pkg::*;

  req_t      req;
  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  strobe_t   strb;
  logic      strb_last;

  // request fields gathered for the datapath
  assign req.mode         = in_req.mode;
  assign req.value        = in_req.value;
  assign req.col          = in_req.col;
  assign req.row          = in_req.row;
  assign req.cursor_show  = in_req.cursor_show;
  assign req.cursor_blink = in_req.cursor_blink;

  // state machine: handshakes and step counter
  clcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_strb.valid),
    .out_ready (out_strb.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: request latch, strobe table and output register
  clcd_datapath #(
    .ROW_TWO_BASE (ROW_TWO_BASE)
  ) u_datapath (
    .clk       (clk),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .strb      (strb),
    .strb_last (strb_last)
  );

  assign out_strb.reg_select     = strb.rs;
  assign out_strb.nibble         = strb.nibble;
  assign out_strb.wait_before_us = strb.wait_before;
  assign out_strb.wait_after_us  = strb.wait_after;
  assign out_strb.last           = strb_last;

endmodule
